FILE: sv/bqf_pkg.sv
// Shared types and codes for the bounded event queue.
// Used by bqf_front, bqf_back and the top level bounded_queue_with_full_policy.
package bqf_pkg;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_TAKE = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  localparam logic [1:0] POL_DROP_NEWEST = 2'd0;
  localparam logic [1:0] POL_DROP_OLDEST = 2'd1;
  localparam logic [1:0] POL_BLOCK       = 2'd2;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_POLICY   = 2'd1;

  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_EVICTED  = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_EXPORTED = 3'd5,
    ST_EMPTY    = 3'd6,
    ST_STOPPED  = 3'd7
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        valid;
    logic [4:0]  fill;
    logic [31:0] accepted;
    logic [31:0] dropped;
    logic [31:0] exported;
    logic        drained;
  } meta_t;

endpackage

FILE: sv/bqf_front.sv
// Front end of the event queue: classifies each command against the fill state.
// Keeps the ring pointers, fill count, stop flag and totals; depends on bqf_pkg.
module bqf_front import bqf_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int EVENT_WIDTH = 64,
  parameter int ADDR_W      = 4,
  parameter int CNT_W       = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [1:0]             command,
  input  logic [63:0]            event_data,
  input  logic [4:0]             capacity,
  input  logic [1:0]             policy,
  output meta_t                  op_meta,
  output logic                   op_wr_en,
  output logic [ADDR_W-1:0]      op_wr_addr,
  output logic [EVENT_WIDTH-1:0] op_wr_data,
  output logic                   op_rd_en,
  output logic [ADDR_W-1:0]      op_rd_addr
);

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  logic [ADDR_W-1:0] head_r, head_nxt, tail_r, tail_nxt, head_inc, tail_inc;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [31:0]       acc_r, acc_nxt, drop_r, drop_nxt, exp_r, exp_nxt;
  logic              stop_r, stop_nxt;
  logic              is_full;
  status_t           status;
  logic              take_valid;

  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;

  always_comb begin
    if (held_r == DEPTH_CNT) begin
      is_full = 1'b1;
    end else if (capacity == 5'd0) begin
      is_full = (held_r != '0);
    end else begin
      is_full = (32'(held_r) >= 32'(capacity));
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    held_nxt   = held_r;
    acc_nxt    = acc_r;
    drop_nxt   = drop_r;
    exp_nxt    = exp_r;
    stop_nxt   = stop_r;
    op_wr_en   = 1'b0;
    op_rd_en   = 1'b0;
    take_valid = 1'b0;
    status     = ST_STOPPED;
    case (command)
      CMD_PUSH: begin
        if (stop_r) begin
          status = ST_IGNORED;
        end else if (is_full) begin
          case (policy)
            POL_DROP_NEWEST: begin
              drop_nxt = drop_r + 32'd1;
              status   = ST_DROPPED;
            end
            POL_DROP_OLDEST: begin
              head_nxt = head_inc;
              tail_nxt = tail_inc;
              op_wr_en = 1'b1;
              drop_nxt = drop_r + 32'd1;
              acc_nxt  = acc_r + 32'd1;
              status   = ST_EVICTED;
            end
            default: begin
              status = ST_BLOCKED;
            end
          endcase
        end else begin
          tail_nxt = tail_inc;
          held_nxt = held_r + 1'b1;
          op_wr_en = 1'b1;
          acc_nxt  = acc_r + 32'd1;
          status   = ST_ACCEPTED;
        end
      end
      CMD_TAKE: begin
        if (held_r == '0) begin
          status = ST_EMPTY;
        end else begin
          head_nxt   = head_inc;
          held_nxt   = held_r - 1'b1;
          op_rd_en   = 1'b1;
          take_valid = 1'b1;
          exp_nxt    = exp_r + 32'd1;
          status     = ST_EXPORTED;
        end
      end
      default: begin
        stop_nxt = 1'b1;
        status   = ST_STOPPED;
      end
    endcase
  end

  assign op_wr_addr = tail_r;
  assign op_rd_addr = head_r;
  assign op_wr_data = event_data[EVENT_WIDTH-1:0];

  assign op_meta.status   = status;
  assign op_meta.valid    = take_valid;
  assign op_meta.fill     = 5'(held_nxt);
  assign op_meta.accepted = acc_nxt;
  assign op_meta.dropped  = drop_nxt;
  assign op_meta.exported = exp_nxt;
  assign op_meta.drained  = (held_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      held_r <= '0;
      acc_r  <= '0;
      drop_r <= '0;
      exp_r  <= '0;
      stop_r <= 1'b0;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      held_r <= held_nxt;
      acc_r  <= acc_nxt;
      drop_r <= drop_nxt;
      exp_r  <= exp_nxt;
      stop_r <= stop_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) held_r <= DEPTH_CNT)
    else $error("Fill count exceeds the queue depth.");

  assert property (@(posedge clk) disable iff (!rst_n) stop_r |=> stop_r)
    else $error("Stop flag cleared without reset.");

  assert property (@(posedge clk) disable iff (!rst_n)
      (accept && op_wr_en && !op_rd_en && op_meta.status == ST_ACCEPTED) |=> held_r != '0)
    else $error("Accepted push left the queue empty.");

endmodule

FILE: sv/bqf_opq.sv
// Two-entry operation queue that decouples the front end from the back end.
// Carries packed operation words; no package dependencies.
module bqf_opq #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_wr ? !wptr_r : wptr_r;
    rptr_nxt  = do_rd ? !rptr_r : rptr_r;
    count_nxt = count_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= 2'd2)
    else $error("Operation queue count out of range.");

  assert property (@(posedge clk) disable iff (!rst_n)
      (count_r == 2'd2 && !rd_en) |=> count_r == 2'd2)
    else $error("Operation queue lost an entry.");

endmodule

FILE: sv/bqf_back.sv
// Back end of the event queue: event memory, read stage and result register.
// Executes operations from bqf_opq in order; depends on bqf_pkg.
module bqf_back import bqf_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int EVENT_WIDTH = 64,
  parameter int ADDR_W      = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   op_avail,
  input  meta_t                  op_meta,
  input  logic                   op_wr_en,
  input  logic [ADDR_W-1:0]      op_wr_addr,
  input  logic [EVENT_WIDTH-1:0] op_wr_data,
  input  logic                   op_rd_en,
  input  logic [ADDR_W-1:0]      op_rd_addr,
  output logic                   op_pop,
  input  logic                   pop,
  output logic                   empty,
  output meta_t                  res_meta,
  output logic [63:0]            res_data
);

  logic [EVENT_WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [EVENT_WIDTH-1:0] rd_data_r;
  meta_t                  s1_meta_r, res_meta_r;
  logic [63:0]            res_data_r;
  logic                   s1_v_r, s1_v_nxt, out_v_r, out_v_nxt;
  logic                   issue, s1_adv;

  assign s1_adv = s1_v_r && (!out_v_r || pop);
  assign issue  = op_avail && (!s1_v_r || s1_adv);
  assign op_pop = issue;

  always_comb begin
    s1_v_nxt  = issue ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    out_v_nxt = s1_adv ? 1'b1 : ((pop && out_v_r) ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (issue && op_wr_en) begin
      mem[op_wr_addr] <= op_wr_data;
    end
    if (issue && op_rd_en) begin
      rd_data_r <= mem[op_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta_r <= op_meta;
    end
    if (s1_adv) begin
      res_meta_r <= s1_meta_r;
      res_data_r <= s1_meta_r.valid ? 64'(rd_data_r) : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign empty    = !out_v_r;
  assign res_meta = res_meta_r;
  assign res_data = res_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
      out_v_r |-> (res_meta_r.valid == (res_meta_r.status == ST_EXPORTED)))
    else $error("Export flag disagrees with status.");

  assert property (@(posedge clk) disable iff (!rst_n)
      (out_v_r && !res_meta_r.valid) |-> res_data_r == 64'd0)
    else $error("Data present on a result that exports nothing.");

endmodule

FILE: sv/bounded_queue_with_full_policy.sv
// Top level of the bounded event queue with a configurable full policy.
// Instantiates bqf_front, bqf_opq and bqf_back; depends on bqf_pkg.
//
// Usage: commands enter through push/full with in_command and in_event_data.
// Each accepted command yields exactly one result, read through empty/pop on
// the out_ ports in command order. Each operation passes through the operation
// queue, the read stage and the result register, and one command per cycle is
// sustained in both directions while pop is held high. The front end decides
// each command's status from its own fill count in the transfer cycle; the back
// end's event memory port allows one write and one registered read per cycle.
// Configuration writes use cfg_valid/cfg_ready, which is always ready: index 0
// sets the capacity, index 1 the full policy, other indexes are ignored.
// Write configuration only while no result is outstanding.
// Reset (rst_n low, synchronous) empties the queue, clears the totals and the
// stop flag, and restores capacity 16 with the drop-newest policy. Memory
// contents are not cleared and no clearing pass is needed.
// When the receiver stalls, up to four results are buffered before full rises.
module bounded_queue_with_full_policy import bqf_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int EVENT_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_event_data,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [63:0] out_out_data,
  output logic        out_out_valid,
  output logic [4:0]  out_fill_level,
  output logic [31:0] out_accepted_total,
  output logic [31:0] out_dropped_total,
  output logic [31:0] out_exported_total,
  output logic        out_drained,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int OP_W   = $bits(meta_t) + 2 + 2 * ADDR_W + EVENT_WIDTH;

  logic [4:0]             capacity_r;
  logic [1:0]             policy_r;
  logic                   accept;
  meta_t                  f_meta, b_meta, res_meta;
  logic                   f_wr_en, f_rd_en, b_wr_en, b_rd_en;
  logic [ADDR_W-1:0]      f_wr_addr, f_rd_addr, b_wr_addr, b_rd_addr;
  logic [EVENT_WIDTH-1:0] f_wr_data, b_wr_data;
  logic [OP_W-1:0]        q_in, q_out;
  logic                   q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;
  assign full      = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
      policy_r   <= POL_DROP_NEWEST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CAPACITY) begin
        capacity_r <= cfg_data;
      end else if (cfg_index == CFG_POLICY) begin
        policy_r <= cfg_data[1:0];
      end
    end
  end

  bqf_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .EVENT_WIDTH (EVENT_WIDTH),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .event_data (in_event_data),
    .capacity   (capacity_r),
    .policy     (policy_r),
    .op_meta    (f_meta),
    .op_wr_en   (f_wr_en),
    .op_wr_addr (f_wr_addr),
    .op_wr_data (f_wr_data),
    .op_rd_en   (f_rd_en),
    .op_rd_addr (f_rd_addr)
  );

  assign q_in = {f_meta, f_wr_en, f_rd_en, f_wr_addr, f_rd_addr, f_wr_data};

  bqf_opq #(
    .WIDTH (OP_W)
  ) u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (q_in),
    .rd_en   (q_pop),
    .rd_data (q_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign {b_meta, b_wr_en, b_rd_en, b_wr_addr, b_rd_addr, b_wr_data} = q_out;

  bqf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .EVENT_WIDTH (EVENT_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_avail   (!q_empty),
    .op_meta    (b_meta),
    .op_wr_en   (b_wr_en),
    .op_wr_addr (b_wr_addr),
    .op_wr_data (b_wr_data),
    .op_rd_en   (b_rd_en),
    .op_rd_addr (b_rd_addr),
    .op_pop     (q_pop),
    .pop        (pop),
    .empty      (empty),
    .res_meta   (res_meta),
    .res_data   (out_out_data)
  );

  assign out_status         = res_meta.status;
  assign out_out_valid      = res_meta.valid;
  assign out_fill_level     = res_meta.fill;
  assign out_accepted_total = res_meta.accepted;
  assign out_dropped_total  = res_meta.dropped;
  assign out_exported_total = res_meta.exported;
  assign out_drained        = res_meta.drained;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for bounded_queue_with_full_policy, the bounded event queue.
// A scoreboard class predicts every result, and plain tasks drive the command and config ports.
// Depends on bqf_pkg and the block's RTL only.
module testbench;
  import bqf_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int EVENT_WIDTH = 64;
  localparam int LONG_HOLD = 150;
  localparam logic [1:0] CMD_STOP_ALT = 2'd3;
  localparam logic [1:0] POL_BLOCK_ALT = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct {
    status_t     status;
    logic [63:0] data;
    logic        valid;
    logic [4:0]  fill;
    logic [31:0] accepted;
    logic [31:0] dropped;
    logic [31:0] exported;
    logic        drained;
  } event_result_t;

  class event_queue_scoreboard;
    logic [63:0]   slots [QUEUE_DEPTH];
    int unsigned   head;
    int unsigned   tail;
    int unsigned   held;
    logic [31:0]   accepted;
    logic [31:0]   dropped;
    logic [31:0]   exported;
    bit            stopped;
    logic [4:0]    capacity;
    logic [1:0]    policy;
    event_result_t expected_results [$];
    int            errors;
    int            checked;
    int            status_seen [8];

    function new();
      head = 0;
      tail = 0;
      held = 0;
      accepted = '0;
      dropped = '0;
      exported = '0;
      stopped = 1'b0;
      capacity = CAPACITY_RESET;
      policy = POL_DROP_NEWEST;
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [4:0] value);
      case (index)
        CFG_CAPACITY: capacity = value;
        CFG_POLICY:   policy = value[1:0];
        default: ;
      endcase
    endfunction

    function int unsigned room();
      if (capacity == 0) return 1;
      if (capacity > QUEUE_DEPTH) return QUEUE_DEPTH;
      return capacity;
    endfunction

    function void enqueue(logic [63:0] data);
      slots[tail] = data;
      tail = (tail + 1) % QUEUE_DEPTH;
      held++;
      accepted += 32'd1;
    endfunction

    function logic [63:0] dequeue();
      logic [63:0] data;
      data = slots[head];
      head = (head + 1) % QUEUE_DEPTH;
      held--;
      return data;
    endfunction

    function void note_command(logic [1:0] command, logic [63:0] data);
      event_result_t r;
      r.data = '0;
      r.valid = 1'b0;
      case (command)
        CMD_PUSH: begin
          if (stopped) begin
            r.status = ST_IGNORED;
          end else if (held >= room()) begin
            case (policy)
              POL_DROP_NEWEST: begin
                dropped += 32'd1;
                r.status = ST_DROPPED;
              end
              POL_DROP_OLDEST: begin
                void'(dequeue());
                dropped += 32'd1;
                enqueue(data);
                r.status = ST_EVICTED;
              end
              default: r.status = ST_BLOCKED;
            endcase
          end else begin
            enqueue(data);
            r.status = ST_ACCEPTED;
          end
        end
        CMD_TAKE: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data = dequeue();
            r.valid = 1'b1;
            exported += 32'd1;
            r.status = ST_EXPORTED;
          end
        end
        default: begin
          stopped = 1'b1;
          r.status = ST_STOPPED;
        end
      endcase
      r.fill = held[4:0];
      r.accepted = accepted;
      r.dropped = dropped;
      r.exported = exported;
      r.drained = (held == 0);
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(event_result_t got);
      event_result_t want;
      if (expected_results.size() == 0) begin
        $error("result transfer with no command outstanding, status %0d", got.status);
        errors++;
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      checked++;
      status_seen[int'(want.status)]++;
      compare_field("status", want.status, got.status);
      compare_field("out_data", want.data, got.data);
      compare_field("out_valid", want.valid, got.valid);
      compare_field("fill_level", want.fill, got.fill);
      compare_field("accepted_total", want.accepted, got.accepted);
      compare_field("dropped_total", want.dropped, got.dropped);
      compare_field("exported_total", want.exported, got.exported);
      compare_field("drained", want.drained, got.drained);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_command = CMD_PUSH;
  logic [63:0] in_event_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_status;
  logic [63:0] out_out_data;
  logic        out_out_valid;
  logic [4:0]  out_fill_level;
  logic [31:0] out_accepted_total;
  logic [31:0] out_dropped_total;
  logic [31:0] out_exported_total;
  logic        out_drained;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_CAPACITY;
  logic [4:0]  cfg_data = '0;

  event_queue_scoreboard scoreboard;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int commands_sent = 0;
  int cfg_writes = 0;

  bounded_queue_with_full_policy #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .EVENT_WIDTH(EVENT_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_command(in_command),
    .in_event_data(in_event_data),
    .empty(empty),
    .pop(pop),
    .out_status(out_status),
    .out_out_data(out_out_data),
    .out_out_valid(out_out_valid),
    .out_fill_level(out_fill_level),
    .out_accepted_total(out_accepted_total),
    .out_dropped_total(out_dropped_total),
    .out_exported_total(out_exported_total),
    .out_drained(out_drained),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver counts its own long hold-offs so that the queue backs up into full.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        scoreboard.check_result('{status_t'(out_status), out_out_data, out_out_valid,
                                  out_fill_level, out_accepted_total, out_dropped_total,
                                  out_exported_total, out_drained});
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= 11);
      end
    end
  end

  function automatic logic [63:0] random_event();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic issue(logic [1:0] command, logic [63:0] data);
    if (!no_idle && $urandom_range(99) < 11) begin
      push <= 1'b0;
      @(posedge clk);
    end
    in_command <= command;
    in_event_data <= data;
    push <= 1'b1;
    do @(posedge clk); while (full);
    scoreboard.note_command(command, data);
    commands_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (scoreboard.expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [4:0] value);
    cfg_index <= index;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    scoreboard.write_reg(index, value);
    cfg_writes++;
  endtask

  task automatic configure(logic [4:0] capacity, logic [1:0] policy);
    write_reg(CFG_CAPACITY, capacity);
    write_reg(CFG_POLICY, policy);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_burst(int count, bit allow_stop);
    int         push_pct;
    int         pick;
    logic [1:0] command;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      pick = $urandom_range(99);
      if (allow_stop && pick < 3) command = CMD_STOP;
      else if (allow_stop && pick < 5) command = CMD_STOP_ALT;
      else if ($urandom_range(99) < push_pct) command = CMD_PUSH;
      else command = CMD_TAKE;
      issue(command, random_event());
    end
  endtask

  initial begin
    scoreboard = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    issue(CMD_PUSH, '0);
    issue(CMD_PUSH, '1);
    issue(CMD_TAKE, '0);
    issue(CMD_TAKE, '1);
    issue(CMD_TAKE, '0);
    drain();
    write_reg(CFG_SPARE, 5'd31);
    configure(5'd0, POL_BLOCK);
    issue(CMD_PUSH, 64'h8000_0000_0000_0001);
    issue(CMD_PUSH, random_event());
    issue(CMD_TAKE, '0);
    issue(CMD_TAKE, '0);
    drain();
    configure(5'd2, POL_DROP_OLDEST);
    repeat (3) issue(CMD_PUSH, random_event());
    drain();
    configure(5'd1, POL_DROP_OLDEST);
    issue(CMD_PUSH, random_event());
    drain();
    configure(5'd1, POL_BLOCK_ALT);
    issue(CMD_PUSH, random_event());
    drain();
    configure(5'd1, POL_DROP_NEWEST);
    issue(CMD_PUSH, random_event());
    repeat (3) issue(CMD_TAKE, '0);
    drain();

    configure(5'd31, POL_DROP_OLDEST);
    random_burst(130, 1'b0);
    drain();
    configure(5'd4, POL_BLOCK);
    hold_req = 1'b1;
    random_burst(130, 1'b0);
    drain();
    configure(5'd1, POL_DROP_NEWEST);
    random_burst(110, 1'b0);
    drain();
    configure(5'd16, POL_BLOCK_ALT);
    no_idle = 1'b1;
    random_burst(130, 1'b0);
    drain();
    no_idle = 1'b0;
    configure(5'd8, POL_DROP_NEWEST);
    hold_req = 1'b1;
    random_burst(130, 1'b0);
    drain();

    configure(5'd3, POL_DROP_OLDEST);
    random_burst(20, 1'b0);
    issue(CMD_STOP, '0);
    issue(CMD_PUSH, random_event());
    random_burst(30, 1'b1);
    repeat (QUEUE_DEPTH + 1) issue(CMD_TAKE, '0);
    issue(CMD_STOP_ALT, '0);
    drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d results from %0d commands across %0d register writes.",
             scoreboard.checked, commands_sent, cfg_writes);
    $display("Status mix: acc %0d evict %0d drop %0d block %0d ign %0d exp %0d empty %0d stop %0d",
             scoreboard.status_seen[0], scoreboard.status_seen[1], scoreboard.status_seen[2],
             scoreboard.status_seen[3], scoreboard.status_seen[4], scoreboard.status_seen[5],
             scoreboard.status_seen[6], scoreboard.status_seen[7]);
    if (scoreboard.errors == 0 && scoreboard.expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
